// ===== hw/rtl/mbrx_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU response receiver package
// Shared constants, command and status types for the receiver modules.
// ----------------------------------------------------------------------------
package mbrx_pkg;

    localparam int WINDOW_DEPTH_DEF = 15;
    localparam logic [7:0]  ADDR_RESET  = 8'h01;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  FC_READ     = 8'h03;
    localparam logic [7:0]  FC_WSINGLE  = 8'h06;
    localparam logic [7:0]  FC_WMULTI   = 8'h10;
    localparam logic [7:0]  READ_COUNT  = 8'h0A;
    localparam int LEN_READ  = 15;
    localparam int LEN_WRITE = 8;
    localparam int LEN_EXC   = 5;

    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_WSINGLE = 2'd1;
    localparam logic [1:0] KIND_WMULTI  = 2'd2;
    localparam logic [1:0] KIND_EXC     = 2'd3;

    typedef struct packed {
        logic push;      // write the accepted byte at the tail
        logic drop;      // shift the window by drop_len
        logic [4:0] drop_len;
        logic crc_clr;   // restart the CRC
        logic crc_step;  // fold the byte at crc_idx into the CRC
        logic [4:0] crc_idx;
        logic emit;      // load the output register
        logic [1:0] kind;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic [4:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic crc_ok_read;
        logic crc_ok_write;
        logic crc_ok_exc;
    } t_status;

endpackage

// ===== hw/rtl/modbus_rtu_response_receiver_top.sv =====
// Each taken byte starts a scan of the window: header check, serial CRC over the frame and
// CRC verify. A good frame leaves the window and its word waits until the scan shows whether
// another frame follows; a bad header or CRC shifts the window by one byte. No byte is taken
// while a scan runs. A waiting word holds off input. Reset: synchronous, active low;
// empties the window, clears the previous flags and sets the slave address to 1.
// ----------------------------------------------------------------------------
// Modbus RTU response receiver top level
// Frames received bytes, checks CRC-16 and unpacks read responses.
// ----------------------------------------------------------------------------
module modbus_rtu_response_receiver_top #(
    parameter int WINDOW_DEPTH = mbrx_pkg::WINDOW_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_frame_kind,
    output logic [6:0]         o_status_flags,
    output logic signed [15:0] o_temperature,
    output logic signed [15:0] o_temperature_offset,
    output logic [15:0]        o_warning_setpoint,
    output logic [15:0]        o_danger_setpoint,
    output logic               o_flags_changed,
    output logic               o_last_frame
);

    logic [7:0] r_slave_address;
    mbrx_pkg::t_cmd    cmd;
    mbrx_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= mbrx_pkg::ADDR_RESET;
        end else if (i_cfg_we) begin
            r_slave_address <= i_cfg_wdata;
        end
    end

    mbrx_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_slave_address (r_slave_address),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    mbrx_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_rx_byte            (i_rx_byte),
        .i_cmd                (cmd),
        .i_out_take           (o_out_valid && !i_out_stall),
        .o_status             (status),
        .o_out_valid          (o_out_valid),
        .o_frame_kind         (o_frame_kind),
        .o_status_flags       (o_status_flags),
        .o_temperature        (o_temperature),
        .o_temperature_offset (o_temperature_offset),
        .o_warning_setpoint   (o_warning_setpoint),
        .o_danger_setpoint    (o_danger_setpoint),
        .o_flags_changed      (o_flags_changed),
        .o_last_frame         (o_last_frame)
    );

endmodule

// ===== hw/rtl/mbrx_datapath.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU receiver datapath
// Byte window, serial CRC unit, frame unpacking and output register.
// ----------------------------------------------------------------------------
module mbrx_datapath #(
    parameter int WINDOW_DEPTH = mbrx_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_rx_byte,
    input  mbrx_pkg::t_cmd       i_cmd,
    input  logic                 i_out_take,
    output mbrx_pkg::t_status    o_status,
    output logic                 o_out_valid,
    output logic [1:0]           o_frame_kind,
    output logic [6:0]           o_status_flags,
    output logic signed [15:0]   o_temperature,
    output logic signed [15:0]   o_temperature_offset,
    output logic [15:0]          o_warning_setpoint,
    output logic [15:0]          o_danger_setpoint,
    output logic                 o_flags_changed,
    output logic                 o_last_frame
);

    localparam int IW = $clog2(WINDOW_DEPTH);

    logic [7:0]  r_win [WINDOW_DEPTH];
    logic [4:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_crc_read, r_crc_write, r_crc_exc;
    logic [6:0]  r_prev;
    logic [6:0]  flags;
    logic [7:0]  crc_byte;

    assign flags = {r_win[4][7:4], r_win[4][2:0]};
    assign crc_byte = r_win[i_cmd.crc_idx[IW-1:0]];

    always_comb begin
        logic [15:0] c;
        c = r_crc ^ {8'h00, crc_byte};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ mbrx_pkg::CRC_POLY) : (c >> 1);
        end
        n_crc = c;
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.drop) begin
            n_count = (i_cmd.drop_len >= r_count) ? 5'd0 : r_count - i_cmd.drop_len;
        end else if (i_cmd.push) begin
            n_count = r_count + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drop) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                if (k + int'(i_cmd.drop_len) < int'(r_count)) begin
                    r_win[k] <= r_win[k + int'(i_cmd.drop_len)];
                end
            end
        end else if (i_cmd.push) begin
            r_win[r_count[IW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.crc_clr) begin
            r_crc <= mbrx_pkg::CRC_INIT;
        end else if (i_cmd.crc_step) begin
            r_crc <= n_crc;
            if (i_cmd.crc_idx == 5'(mbrx_pkg::LEN_EXC - 3)) r_crc_exc <= n_crc;
            if (i_cmd.crc_idx == 5'(mbrx_pkg::LEN_WRITE - 3)) r_crc_write <= n_crc;
            if (i_cmd.crc_idx == 5'(mbrx_pkg::LEN_READ - 3)) r_crc_read <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_prev      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_out_take) o_out_valid <= 1'b0;
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
                if (i_cmd.kind == mbrx_pkg::KIND_READ) r_prev <= flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_frame_kind <= i_cmd.kind;
            o_last_frame <= i_cmd.last;
            if (i_cmd.kind == mbrx_pkg::KIND_READ) begin
                o_status_flags       <= flags;
                o_temperature        <= {r_win[5], r_win[6]};
                o_temperature_offset <= {r_win[7], r_win[8]};
                o_warning_setpoint   <= {r_win[9], r_win[10]};
                o_danger_setpoint    <= {r_win[11], r_win[12]};
                o_flags_changed      <= (flags != r_prev);
            end else begin
                o_status_flags       <= '0;
                o_temperature        <= '0;
                o_temperature_offset <= '0;
                o_warning_setpoint   <= '0;
                o_danger_setpoint    <= '0;
                o_flags_changed      <= 1'b0;
            end
        end
    end

    assign o_status.count = r_count;
    assign o_status.b0 = r_win[0];
    assign o_status.b1 = r_win[1];
    assign o_status.b2 = r_win[2];
    assign o_status.crc_ok_read  = (r_crc_read  == {r_win[14], r_win[13]});
    assign o_status.crc_ok_write = (r_crc_write == {r_win[7], r_win[6]});
    assign o_status.crc_ok_exc   = (r_crc_exc   == {r_win[4], r_win[3]});

endmodule

// ===== hw/rtl/mbrx_ctrl.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU receiver controller
// Sequences byte intake, header checks, CRC passes and result delivery.
// ----------------------------------------------------------------------------
module mbrx_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [7:0]        i_slave_address,
    input  mbrx_pkg::t_status i_status,
    output mbrx_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_CRC, S_VERIFY, S_EMIT, S_WAIT
    } t_state;

    t_state     r_state;
    logic [4:0] r_idx, r_len;
    logic [1:0] r_kind;
    logic       r_pend;    // a result waits for the next scan to know last
    logic [1:0] r_pkind;
    logic       hdr_ok;
    logic [4:0] hdr_len;
    logic [1:0] hdr_kind;
    logic       crc_ok;

    always_comb begin
        hdr_ok = 1'b1;
        hdr_len = 5'(mbrx_pkg::LEN_EXC);
        hdr_kind = mbrx_pkg::KIND_EXC;
        if (i_status.b0 != i_slave_address) begin
            hdr_ok = 1'b0;
        end else if (i_status.b1 == mbrx_pkg::FC_READ) begin
            hdr_ok = (i_status.b2 == mbrx_pkg::READ_COUNT);
            hdr_len = 5'(mbrx_pkg::LEN_READ);
            hdr_kind = mbrx_pkg::KIND_READ;
        end else if (i_status.b1 == mbrx_pkg::FC_WSINGLE) begin
            hdr_len = 5'(mbrx_pkg::LEN_WRITE);
            hdr_kind = mbrx_pkg::KIND_WSINGLE;
        end else if (i_status.b1 == mbrx_pkg::FC_WMULTI) begin
            hdr_len = 5'(mbrx_pkg::LEN_WRITE);
            hdr_kind = mbrx_pkg::KIND_WMULTI;
        end else if (!i_status.b1[7]) begin
            hdr_ok = 1'b0;
        end
    end

    always_comb begin
        unique case (r_kind)
            mbrx_pkg::KIND_READ: crc_ok = i_status.crc_ok_read;
            mbrx_pkg::KIND_EXC:  crc_ok = i_status.crc_ok_exc;
            default:             crc_ok = i_status.crc_ok_write;
        endcase
    end

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE) || i_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.crc_idx = r_idx;
        o_cmd.kind = r_pkind;
        o_cmd.drop_len = 5'd1;
        unique case (r_state)
            S_IDLE:  o_cmd.push = i_in_valid && !o_in_stall;
            S_CHECK: begin
                if (i_status.count >= 5'd3 && !hdr_ok) o_cmd.drop = 1'b1;
                o_cmd.crc_clr = 1'b1;
            end
            S_CRC:   o_cmd.crc_step = 1'b1;
            S_VERIFY: begin
                o_cmd.drop = 1'b1;
                o_cmd.drop_len = crc_ok ? r_len : 5'd1;
            end
            S_EMIT: begin
                o_cmd.emit = !i_out_valid || !i_out_stall;
                o_cmd.last = 1'b0;
            end
            S_WAIT: begin
                o_cmd.emit = !i_out_valid || !i_out_stall;
                o_cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_len   <= '0;
            r_kind  <= '0;
            r_pend  <= 1'b0;
            r_pkind <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (o_cmd.push) r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_status.count < 5'd3) begin
                        r_state <= r_pend ? S_WAIT : S_IDLE;
                    end else if (hdr_ok) begin
                        if (i_status.count < hdr_len) begin
                            r_state <= r_pend ? S_WAIT : S_IDLE;
                        end else begin
                            r_len <= hdr_len;
                            r_kind <= hdr_kind;
                            r_idx <= '0;
                            r_state <= S_CRC;
                        end
                    end
                end
                S_CRC: begin
                    r_idx <= r_idx + 5'd1;
                    if (r_idx == r_len - 5'd3) r_state <= S_VERIFY;
                end
                S_VERIFY: begin
                    if (crc_ok) begin
                        r_state <= r_pend ? S_EMIT : S_CHECK;
                        if (!r_pend) begin
                            r_pend <= 1'b1;
                            r_pkind <= r_kind;
                        end
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_EMIT: if (o_cmd.emit) begin
                    r_pkind <= r_kind;
                    r_state <= S_CHECK;
                end
                S_WAIT: if (o_cmd.emit) begin
                    r_pend <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/mbrx_checker.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU receiver port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module mbrx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_frame_kind,
    input logic [6:0]  o_status_flags,
    input logic        o_flags_changed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_kind))
        else $error("Stalled output word changed.");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_kind != mbrx_pkg::KIND_READ |->
        o_status_flags == 7'd0 && !o_flags_changed)
        else $error("Non-read word carries read fields.");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("Input taken while a word waits.");

endmodule

bind modbus_rtu_response_receiver_top mbrx_checker u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_frame_kind    (o_frame_kind),
    .o_status_flags  (o_status_flags),
    .o_flags_changed (o_flags_changed)
);

// ===== dv/modbus_rtu_response_receiver_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response receiver testbench
// Sends framed and noisy byte streams, predicts every reported frame with a
// byte window model of its own and checks each output word field by field.
// ----------------------------------------------------------------------------
module modbus_rtu_response_receiver_top_tb;

    localparam int DEPTH = 15;

    typedef struct {
        logic [1:0]  kind;
        logic [6:0]  flags;
        logic [15:0] temp;
        logic [15:0] offs;
        logic [15:0] warn;
        logic [15:0] dang;
        logic        changed;
        logic        last;
    } t_frame_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_frame_kind;
    logic [6:0]  o_status_flags;
    logic signed [15:0] o_temperature;
    logic signed [15:0] o_temperature_offset;
    logic [15:0] o_warning_setpoint;
    logic [15:0] o_danger_setpoint;
    logic        o_flags_changed;
    logic        o_last_frame;

    t_frame_word frames_due[$];
    logic [7:0]  rx_window[DEPTH];
    int          rx_count;
    logic [6:0]  last_flags;
    logic [7:0]  station_addr;
    int          error_count = 0;
    int          bytes_sent = 0;
    bit          idling_on = 1'b1;
    int          out_burst = 0;

    modbus_rtu_response_receiver_top u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_frame_kind(o_frame_kind),
        .o_status_flags(o_status_flags),
        .o_temperature(o_temperature),
        .o_temperature_offset(o_temperature_offset),
        .o_warning_setpoint(o_warning_setpoint),
        .o_danger_setpoint(o_danger_setpoint),
        .o_flags_changed(o_flags_changed),
        .o_last_frame(o_last_frame)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [15:0] crc16(input logic [7:0] b[DEPTH], input int len);
        logic [15:0] c;
        c = mbrx_pkg::CRC_INIT;
        for (int i = 0; i < len; i++) begin
            c = c ^ {8'h00, b[i]};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ mbrx_pkg::CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

    function automatic void window_drop(input int n);
        if (n >= rx_count) begin
            rx_count = 0;
        end else begin
            for (int i = 0; i < rx_count - n; i++) rx_window[i] = rx_window[i + n];
            rx_count -= n;
        end
    endfunction

    function automatic void predict_frames(input logic [7:0] b);
        t_frame_word got[2];
        t_frame_word w;
        int n;
        int len;
        logic [1:0] kind;
        logic [7:0] fc;
        logic [7:0] s;
        logic [6:0] fl;
        n = 0;
        if (rx_count >= DEPTH) window_drop(1);
        rx_window[rx_count] = b;
        rx_count++;
        while (rx_count >= 3) begin
            if (rx_window[0] != station_addr) begin
                window_drop(1);
                continue;
            end
            fc = rx_window[1];
            if (fc == mbrx_pkg::FC_READ) begin
                if (rx_window[2] != mbrx_pkg::READ_COUNT) begin
                    window_drop(1);
                    continue;
                end
                len = mbrx_pkg::LEN_READ;
                kind = mbrx_pkg::KIND_READ;
            end else if (fc == mbrx_pkg::FC_WSINGLE) begin
                len = mbrx_pkg::LEN_WRITE;
                kind = mbrx_pkg::KIND_WSINGLE;
            end else if (fc == mbrx_pkg::FC_WMULTI) begin
                len = mbrx_pkg::LEN_WRITE;
                kind = mbrx_pkg::KIND_WMULTI;
            end else if (fc[7]) begin
                len = mbrx_pkg::LEN_EXC;
                kind = mbrx_pkg::KIND_EXC;
            end else begin
                window_drop(1);
                continue;
            end
            if (rx_count < len) break;
            if (crc16(rx_window, len - 2) != {rx_window[len - 1], rx_window[len - 2]}) begin
                window_drop(1);
                continue;
            end
            if (n < 2) begin
                w = '{kind: kind, default: '0};
                if (kind == mbrx_pkg::KIND_READ) begin
                    s = rx_window[4];
                    fl = {s[7:4], s[2:0]};
                    w.flags = fl;
                    w.temp = {rx_window[5], rx_window[6]};
                    w.offs = {rx_window[7], rx_window[8]};
                    w.warn = {rx_window[9], rx_window[10]};
                    w.dang = {rx_window[11], rx_window[12]};
                    w.changed = (fl != last_flags);
                    last_flags = fl;
                end
                got[n] = w;
                n++;
            end
            window_drop(len);
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) got[i].last = 1'b1;
            frames_due = {frames_due, got[i]};
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        predict_frames(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [1:0] kind, input logic [7:0] fa, input bit corrupt,
                              input logic [7:0] status, input logic [15:0] t,
                              input logic [15:0] o, input logic [15:0] w,
                              input logic [15:0] d);
        logic [7:0] f[DEPTH];
        int len;
        logic [15:0] c;
        foreach (f[i]) f[i] = 8'($urandom_range(0, 255));
        f[0] = fa;
        case (kind)
            mbrx_pkg::KIND_READ: begin
                f[1] = mbrx_pkg::FC_READ;
                f[2] = mbrx_pkg::READ_COUNT;
                f[4] = status;
                {f[5], f[6], f[7], f[8]} = {t, o};
                {f[9], f[10], f[11], f[12]} = {w, d};
                len = mbrx_pkg::LEN_READ;
            end
            mbrx_pkg::KIND_WSINGLE: begin
                f[1] = mbrx_pkg::FC_WSINGLE;
                len = mbrx_pkg::LEN_WRITE;
            end
            mbrx_pkg::KIND_WMULTI: begin
                f[1] = mbrx_pkg::FC_WMULTI;
                len = mbrx_pkg::LEN_WRITE;
            end
            default: begin
                f[1] = f[1] | 8'h80;
                len = mbrx_pkg::LEN_EXC;
            end
        endcase
        c = crc16(f, len - 2);
        f[len - 2] = c[7:0];
        f[len - 1] = c[15:8];
        if (corrupt) f[len - 1][$urandom_range(0, 7)] ^= 1'b1;
        for (int i = 0; i < len; i++) send_byte(f[i]);
    endtask

    task automatic random_frame(input bit corrupt);
        send_frame(2'($urandom_range(0, 3)), station_addr, corrupt,
                   8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_address(input logic [7:0] a);
        wait_drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= a;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        station_addr = a;
    endtask

    task automatic test_frame_kinds();
        for (int k = 0; k < 4; k++) random_frame(1'b0);
        send_frame(mbrx_pkg::KIND_EXC, station_addr, 1'b0, 8'h00,
                   16'h0, 16'h0, 16'h0, 16'h0);
        send_frame(mbrx_pkg::KIND_WSINGLE, station_addr, 1'b0, 8'h00,
                   16'h0, 16'h0, 16'h0, 16'h0);
        send_frame(mbrx_pkg::KIND_WMULTI, station_addr, 1'b0, 8'h00,
                   16'h0, 16'h0, 16'h0, 16'h0);
    endtask

    task automatic test_read_extremes();
        send_frame(mbrx_pkg::KIND_READ, station_addr, 1'b0, 8'hFF,
                   16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
        send_frame(mbrx_pkg::KIND_READ, station_addr, 1'b0, 8'hFF,
                   16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
        send_frame(mbrx_pkg::KIND_READ, station_addr, 1'b0, 8'h00,
                   16'hFFFF, 16'h0000, 16'h1234, 16'h5678);
    endtask

    task automatic test_bad_frames();
        send_frame(mbrx_pkg::KIND_READ, station_addr, 1'b1, 8'h5A,
                   16'h0101, 16'h0202, 16'h0303, 16'h0404);
        send_frame(mbrx_pkg::KIND_WSINGLE, station_addr ^ 8'h01, 1'b0, 8'h0,
                   16'h0, 16'h0, 16'h0, 16'h0);
        send_byte(station_addr);
        send_byte(mbrx_pkg::FC_READ);
        send_byte(8'h0B);
        send_byte(station_addr);
        send_byte(8'h05);
        send_frame(mbrx_pkg::KIND_EXC, station_addr, 1'b0, 8'h0,
                   16'h0, 16'h0, 16'h0, 16'h0);
    endtask

    task automatic test_address_config();
        set_address(8'h00);
        test_frame_kinds();
        set_address(8'hFF);
        test_read_extremes();
        random_frame(1'b0);
        set_address(mbrx_pkg::ADDR_RESET);
    endtask

    task automatic test_random_traffic(input int target);
        int pick;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                random_frame(1'b0);
            end else if (pick < 75) begin
                random_frame(1'b1);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 92) begin
                send_byte(station_addr);
                send_byte($urandom_range(0, 1) ? mbrx_pkg::FC_READ
                                               : 8'h80 | 8'($urandom_range(0, 127)));
            end else if (pick < 97) begin
                send_frame(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0,
                           8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
            end else begin
                set_address(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_drain_pause();
        random_frame(1'b0);
        wait_drain();
        random_frame(1'b0);
    endtask

    task automatic test_no_idle();
        idling_on = 1'b0;
        repeat (8) random_frame(1'b0);
    endtask

    task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (e !== a) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, e, a);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (out_burst > 0) begin
            out_burst <= out_burst - 1;
            i_out_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            out_burst <= $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_frame_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frames_due.size() == 0) begin
                $error("unexpected word: frame_kind 0x%0h", o_frame_kind);
                error_count++;
            end else begin
                e = frames_due.pop_front();
                check_field("frame_kind", 16'(e.kind), 16'(o_frame_kind));
                check_field("status_flags", 16'(e.flags), 16'(o_status_flags));
                check_field("temperature", e.temp, o_temperature);
                check_field("temperature_offset", e.offs, o_temperature_offset);
                check_field("warning_setpoint", e.warn, o_warning_setpoint);
                check_field("danger_setpoint", e.dang, o_danger_setpoint);
                check_field("flags_changed", 16'(e.changed), 16'(o_flags_changed));
                check_field("last_frame", 16'(e.last), 16'(o_last_frame));
            end
        end
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        rx_count = 0;
        last_flags = '0;
        station_addr = mbrx_pkg::ADDR_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_frame_kinds();
        test_read_extremes();
        test_bad_frames();
        test_address_config();
        test_random_traffic(460);
        test_drain_pause();
        set_address(mbrx_pkg::ADDR_RESET);
        test_no_idle();
        wait_drain();
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
